/* design/pixel_depth_repacker_macros.svh */
// Assertion macros shared by the pixel depth repacker RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef PIXEL_DEPTH_REPACKER_MACROS_SVH
`define PIXEL_DEPTH_REPACKER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define PDR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdr check failed: label");
// Next-cycle implication, disabled while reset is asserted
`define PDR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdr check failed: label");
`else
`define PDR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PDR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/pdr_pkg.sv */
// Package for the pixel depth repacker: transaction types, depth codes,
// register indexes and the pixel bit-extraction helpers. No dependencies.
`default_nettype none

package pdr_pkg;

  // Depth codes (bits per pixel)
  localparam logic [3:0] DEPTH_8 = 4'd8;
  localparam logic [3:0] DEPTH_4 = 4'd4;
  localparam logic [3:0] DEPTH_2 = 4'd2;
  localparam logic [3:0] DEPTH_1 = 4'd1;

  // Reset values of the depth registers
  localparam logic [3:0] SOURCE_BITS_RST = DEPTH_8;
  localparam logic [3:0] TARGET_BITS_RST = DEPTH_1;

  // Register indexes (byte address 4*index)
  typedef enum logic {
    REG_SOURCE_BITS = 1'b0,
    REG_TARGET_BITS = 1'b1
  } reg_idx_t;

  // Conversion mode of a depth pair
  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_CONV = 2'd1,
    MODE_BAD  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       row_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       row_end;
    logic       status;
  } out_item_t;

  // Kept bits of one source byte: right aligned, with their count
  typedef struct packed {
    logic [2:0] nbits;
    logic [3:0] bits;
  } keep_t;

  function automatic mode_t pdr_mode(input logic [3:0] src, input logic [3:0] tgt);
    mode_t m;
    m = MODE_BAD;
    if (src == tgt && (src == DEPTH_8 || src == DEPTH_4 || src == DEPTH_2 ||
                       src == DEPTH_1)) begin
      m = MODE_PASS;
    end else if ((src == DEPTH_8 && (tgt == DEPTH_4 || tgt == DEPTH_2 || tgt == DEPTH_1)) ||
                 (src == DEPTH_4 && (tgt == DEPTH_2 || tgt == DEPTH_1)) ||
                 (src == DEPTH_2 && tgt == DEPTH_1)) begin
      m = MODE_CONV;
    end
    return m;
  endfunction

  // Low target bits of every source pixel, MSB-first
  function automatic keep_t pdr_keep(input logic [3:0] src, input logic [3:0] tgt,
                                     input logic [7:0] b);
    keep_t k;
    k = '0;
    case ({src, tgt})
      {DEPTH_8, DEPTH_4}: k = '{nbits: 3'd4, bits: b[3:0]};
      {DEPTH_8, DEPTH_2}: k = '{nbits: 3'd2, bits: {2'b00, b[1:0]}};
      {DEPTH_8, DEPTH_1}: k = '{nbits: 3'd1, bits: {3'b000, b[0]}};
      {DEPTH_4, DEPTH_2}: k = '{nbits: 3'd4, bits: {b[5:4], b[1:0]}};
      {DEPTH_4, DEPTH_1}: k = '{nbits: 3'd2, bits: {2'b00, b[4], b[0]}};
      {DEPTH_2, DEPTH_1}: k = '{nbits: 3'd4, bits: {b[6], b[4], b[2], b[0]}};
      default:            k = '0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* design/pixel_depth_repacker.sv */
// Pixel depth repacker top level: input register, packing logic, result register.
// Depends on pdr_pkg and pixel_depth_repacker_macros.svh.
`default_nettype none

// Takes one source row byte per clock while not stalled (pixels MSB-first at
// 8, 4 or 2 bpp) and keeps the low target_bits of each pixel, packing them
// MSB-first into output bytes at 4, 2 or 1 bpp. A byte comes out when it fills
// or at the last source byte of a row (row_last), zero padded on the right.
// Equal depths pass bytes through; an unsupported pair returns status 1 with
// out_byte 0 for every byte. A source byte goes through the input register and
// then the result register before out_valid rises; while the output stalls it
// waits in the input register. Bytes that do not complete an output byte
// produce no transaction. Writing either depth register clears the partial
// byte; write only while the block is idle.

`include "pixel_depth_repacker_macros.svh"

module pixel_depth_repacker
  import pdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // source byte channel
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire in_item_t    in_data,
  // packed byte channel
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      out_item_t   out_data,
  // register port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  logic [3:0] source_bits_r;
  logic [3:0] target_bits_r;
  logic [7:0] acc_r,  acc_nxt;
  logic [2:0] fill_r, fill_nxt;
  logic       s1_valid_r;
  in_item_t   s1_data_r;
  logic       out_valid_r;
  out_item_t  out_data_r, out_data_nxt;

  logic       cfg_wr;
  reg_idx_t   cfg_idx;
  mode_t      mode;
  keep_t      keep;
  logic [7:0] acc_new;
  logic [3:0] cnt_new;
  logic       full;
  logic       emit;
  logic       out_free;
  logic       s1_go;
  logic       in_acc;

  // register port decode
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_comb begin
    case (cfg_idx)
      REG_SOURCE_BITS: prdata = {28'd0, source_bits_r};
      REG_TARGET_BITS: prdata = {28'd0, target_bits_r};
      default:         prdata = 32'd0;
    endcase
  end

  // handshake control
  assign mode     = pdr_mode(source_bits_r, target_bits_r);
  assign out_free = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && (out_free || !emit);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  // packing datapath on the registered input byte
  assign keep    = pdr_keep(source_bits_r, target_bits_r, s1_data_r.in_byte);
  assign acc_new = (acc_r << keep.nbits) | {4'd0, keep.bits};
  assign cnt_new = {1'b0, fill_r} + {1'b0, keep.nbits};
  assign full    = cnt_new[3];

  always_comb begin
    emit         = 1'b1;
    acc_nxt      = acc_r;
    fill_nxt     = fill_r;
    out_data_nxt = '{out_byte: s1_data_r.in_byte, row_end: s1_data_r.row_last,
                     status: 1'b0};
    case (mode)
      MODE_PASS: begin
        emit = 1'b1;
      end
      MODE_CONV: begin
        if (full) begin
          out_data_nxt.out_byte = acc_new;
          acc_nxt  = 8'd0;
          fill_nxt = 3'd0;
        end else if (s1_data_r.row_last) begin
          // flush a partial byte, padded with zeros on the right
          out_data_nxt.out_byte = acc_new << (4'd8 - cnt_new);
          acc_nxt  = 8'd0;
          fill_nxt = 3'd0;
        end else begin
          emit     = 1'b0;
          acc_nxt  = acc_new;
          fill_nxt = cnt_new[2:0];
        end
      end
      default: begin
        out_data_nxt.out_byte = 8'd0;
        out_data_nxt.status   = 1'b1;
      end
    endcase
  end

  // config registers and pack state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_bits_r <= SOURCE_BITS_RST;
      target_bits_r <= TARGET_BITS_RST;
      acc_r         <= 8'd0;
      fill_r        <= 3'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SOURCE_BITS: source_bits_r <= pwdata[3:0];
        REG_TARGET_BITS: target_bits_r <= pwdata[3:0];
        default: ;
      endcase
      acc_r  <= 8'd0;
      fill_r <= 3'd0;
    end else if (s1_go) begin
      acc_r  <= acc_nxt;
      fill_r <= fill_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_go && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `PDR_ASSERT_IMP(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_r)
  `PDR_ASSERT_NXT(a_emit_loads_out, clk, rst_n, s1_go && emit, out_valid_r)
  `PDR_ASSERT_IMP(a_idle_state_clear, clk, rst_n, mode != MODE_CONV, fill_r == 3'd0)
  `PDR_ASSERT_IMP(a_fill_aligned, clk, rst_n, s1_valid_r && mode == MODE_CONV,
                  (fill_r & (keep.nbits - 3'd1)) == 3'd0)

endmodule

`default_nettype wire

/* tb/pdr_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the pixel depth repacker: follows depth register writes,
// predicts each packed byte from the accepted source bytes and compares it.
// Depends on pdr_pkg for transaction types, depth codes and register indexes.

module pdr_checker
  import pdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatch_count,
  output int          due_count,
  output int          compared_count
);

  // Local copy of the depth registers and the partial output byte
  logic [3:0] src_bits;
  logic [3:0] tgt_bits;
  logic [7:0] pack_acc;
  int         fill_cnt;

  out_item_t  due_bytes[$];
  int         n_bad;
  int         n_compared;

  function automatic bit is_depth(input logic [3:0] d);
    return d == DEPTH_8 || d == DEPTH_4 || d == DEPTH_2 || d == DEPTH_1;
  endfunction

  // Legal depths with target not above source; equal depths pass through
  function automatic mode_t pair_mode(input logic [3:0] s, input logic [3:0] t);
    if (!is_depth(s) || !is_depth(t) || t > s) return MODE_BAD;
    return (s == t) ? MODE_PASS : MODE_CONV;
  endfunction

  // Packs one source byte; returns 1 when a packed byte comes out
  function automatic bit repack(input in_item_t it, output out_item_t res);
    int         npix;
    int         cnt;
    int         p;
    logic [7:0] acc;
    logic [7:0] pix_mask;
    logic [7:0] v;
    bit         full;
    res = '0;
    case (pair_mode(src_bits, tgt_bits))
      MODE_PASS: begin
        res.out_byte = it.in_byte;
        res.row_end  = it.row_last;
        return 1'b1;
      end
      MODE_BAD: begin
        res.row_end = it.row_last;
        res.status  = 1'b1;
        return 1'b1;
      end
      default: ;
    endcase

    acc      = pack_acc;
    cnt      = fill_cnt;
    full     = 1'b0;
    npix     = 8 / src_bits;
    pix_mask = 8'((1 << tgt_bits) - 1);
    // every pixel slot counts, padding pixels of the row included
    for (p = 0; p < npix && !full; p++) begin
      v   = (it.in_byte >> (8 - src_bits * (p + 1))) & pix_mask;
      acc = (acc << tgt_bits) | v;
      cnt = cnt + tgt_bits;
      if (cnt >= 8) begin
        full = 1'b1;
        cnt  = 0;
      end
    end

    // full byte, or a partial byte flushed left-aligned at row end
    if (full || it.row_last) begin
      res.out_byte = full ? acc : 8'(acc << (8 - cnt));
      res.row_end  = it.row_last;
      pack_acc     = '0;
      fill_cnt     = 0;
      return 1'b1;
    end
    pack_acc = acc;
    fill_cnt = cnt;
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    out_item_t predicted;
    out_item_t want;
    if (!rst_n) begin
      src_bits   = SOURCE_BITS_RST;
      tgt_bits   = TARGET_BITS_RST;
      pack_acc   = '0;
      fill_cnt   = 0;
      n_bad      = 0;
      n_compared = 0;
      due_bytes.delete();
    end else begin
      // register write: either depth clears the partial byte
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        if (reg_idx_t'(paddr[2]) == REG_SOURCE_BITS) src_bits = pwdata[3:0];
        else tgt_bits = pwdata[3:0];
        pack_acc = '0;
        fill_cnt = 0;
      end

      // source byte transaction
      if (in_valid && !in_stall) begin
        if (repack(in_data, predicted)) due_bytes.push_back(predicted);
      end

      // packed byte transaction
      if (out_valid && !out_stall) begin
        if (due_bytes.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: unexpected packed byte: byte %h row_end %b status %b",
                     $realtime, out_data.out_byte, out_data.row_end, out_data.status);
        end else begin
          want = due_bytes.pop_front();
          n_compared++;
          if (out_data.out_byte !== want.out_byte || out_data.row_end !== want.row_end ||
              out_data.status !== want.status) begin
            n_bad++;
            if (n_bad <= 10)
              $display("%0t: mismatch: expected byte %h row_end %b status %b, got %h %b %b",
                       $realtime, want.out_byte, want.row_end, want.status,
                       out_data.out_byte, out_data.row_end, out_data.status);
          end
        end
      end
    end
    mismatch_count <= n_bad;
    due_count      <= due_bytes.size();
    compared_count <= n_compared;
  end

endmodule

/* tb/tb_pixel_depth_repacker.sv */
`timescale 1ns / 100ps
// Top of the pixel depth repacker testbench: clock, reset, stimulus and verdict.
// Depends on pdr_pkg, pixel_depth_repacker and the pdr_checker scoreboard.

module tb_pixel_depth_repacker;
  import pdr_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int TIMEOUT_CYCLES  = 600000;
  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int LONG_HOLD       = 300;
  localparam int DIR_CASES       = 12;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int due_count;
  int compared_count;

  // stimulus controls shared with the receiver process, and run counters
  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int bytes_sent    = 0;
  int settings_used = 0;

  logic [3:0] depth_ladder [4] = '{DEPTH_8, DEPTH_4, DEPTH_2, DEPTH_1};

  // directed cases: reset defaults, each conversion, pass through, bad pairs
  logic [3:0] dir_src [DIR_CASES] = '{DEPTH_8, DEPTH_8, DEPTH_8, DEPTH_4, DEPTH_4, DEPTH_2,
                                       DEPTH_8, DEPTH_1, 4'd0, 4'd15, DEPTH_1, 4'd3};
  logic [3:0] dir_tgt [DIR_CASES] = '{DEPTH_1, DEPTH_4, DEPTH_2, DEPTH_2, DEPTH_1, DEPTH_1,
                                       DEPTH_8, DEPTH_1, 4'd0, 4'd15, DEPTH_8, DEPTH_1};
  logic [7:0] dir_first [DIR_CASES] = '{8'hFF, 8'hA5, 8'h3C, 8'hC3, 8'h96, 8'hE4,
                                         8'hFF, 8'h00, 8'hFF, 8'h5A, 8'h81, 8'h7E};
  logic [7:0] dir_second [DIR_CASES] = '{8'h00, 8'h5A, 8'hFF, 8'h69, 8'h0F, 8'h1B,
                                          8'h00, 8'hFF, 8'hFF, 8'hA5, 8'h7F, 8'h01};

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  pixel_depth_repacker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  pdr_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .mismatch_count (mismatch_count),
    .due_count      (due_count),
    .compared_count (compared_count)
  );

  // One source byte transaction, with an occasional gap before it
  task automatic send_item(input in_item_t item);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Setup and access phase, then one idle cycle on the bus
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait out every expected byte, then let the pipeline empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Depth change while idle; upper data bits are noise, order is random
  task automatic set_depths(input logic [3:0] s, input logic [3:0] t);
    logic [31:0] w;
    settle();
    w = $urandom;
    if ($urandom_range(0, 1) == 1) begin
      reg_write({REG_SOURCE_BITS, 2'b00}, {w[31:4], s});
      reg_write({REG_TARGET_BITS, 2'b00}, {w[31:4], t});
    end else begin
      reg_write({REG_TARGET_BITS, 2'b00}, {w[31:4], t});
      reg_write({REG_SOURCE_BITS, 2'b00}, {w[31:4], s});
    end
    settings_used++;
  endtask

  // Mostly well-formed rows of random length, with some stray row marks
  task automatic run_rows(input int count);
    in_item_t it;
    int       n;
    int       k;
    int       row_len;
    n = 0;
    while (n < count) begin
      row_len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (k = 0; k < row_len && n < count; k++) begin
        it.in_byte  = 8'($urandom_range(0, 255));
        it.row_last = (k == row_len - 1);
        if ($urandom_range(0, 19) == 0) it.row_last = ~it.row_last;
        send_item(it);
        n++;
      end
    end
  endtask

  // Receiver: random stall bursts, one long hold on request, none when calm
  initial begin
    int hold_n;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (hold_n = 0; hold_n < LONG_HOLD; hold_n++) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    in_item_t   it;
    int         i;
    int         ph;
    int         a;
    int         b;
    int         r;
    logic [3:0] s;
    logic [3:0] t;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: a mid-row byte then a row end under each setting
    for (i = 0; i < DIR_CASES; i++) begin
      if (i > 0) set_depths(dir_src[i], dir_tgt[i]);
      it.in_byte  = dir_first[i];
      it.row_last = 1'b0;
      send_item(it);
      it.in_byte  = dir_second[i];
      it.row_last = 1'b1;
      send_item(it);
    end

    // random phases: mostly conversions, some pass through and bad pairs
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      a = $urandom_range(0, 2);
      b = $urandom_range(a + 1, 3);
      s = depth_ladder[a];
      t = depth_ladder[b];
      r = $urandom_range(0, 9);
      if (r == 8) begin
        t = s;
      end else if (r == 9) begin
        s = 4'($urandom_range(0, 15));
        t = 4'($urandom_range(0, 15));
      end
      // pass through fills the pipeline fastest under the long hold
      if (ph == 1) begin
        s = DEPTH_4;
        t = DEPTH_4;
      end
      if (ph == RAND_PHASES - 1) calm = 1'b1;
      set_depths(s, t);
      if (ph == 1) hold_req = 1'b1;
      run_rows(ITEMS_PER_PHASE);
    end

    settle();
    $display("Run covered %0d source bytes over %0d depth settings after the reset defaults.",
             bytes_sent, settings_used);
    $display("%0d packed bytes compared, %0d failures counted.", compared_count, mismatch_count);
    if (mismatch_count == 0 && due_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/pdr_pkg.sv
design/pixel_depth_repacker.sv
tb/pdr_checker.sv
tb/tb_pixel_depth_repacker.sv
